[sv/fba_pkg.sv]
package fba_pkg;

    localparam int OPCODE_W = 1;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        SEL_GRANT,
        SEL_FREED,
        SEL_NONE,
        SEL_RANGE
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     init_clr;
        logic     pop_rd;
        logic     scan_init;
        logic     map_rd_scan;
        logic     scan_chk;
        logic     fl_rd_stk;
        logic     fl_rd_map;
        logic     fl_wr;
        logic     push;
        logic     set_start_first;
        logic     zero_start;
        logic     load_out;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic req_free;
        logic req_bad;
        logic stack_empty;
        logic stack_full;
        logic clear_zero;
        logic scan_done;
        logic clr_done;
        logic out_free;
    } stat_t;

endpackage

[sv/fba_req_if.sv]
interface fba_req_if;
    logic                        valid;
    logic                        ready;
    logic [fba_pkg::OPCODE_W-1:0] opcode;
    logic [fba_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

[sv/fba_rsp_if.sv]
interface fba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::STATUS_W-1:0] status;
    logic [fba_pkg::IDX_W-1:0]    granted_block;
    logic [fba_pkg::CNT_W-1:0]    free_count;

    modport source (output valid, output status, output granted_block, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_block, input free_count,
                    output ready);
endinterface

[sv/fba_datapath.sv]
module fba_datapath #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int STACK_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fba_pkg::cmd_t                cmd,
    output fba_pkg::stat_t               stat,
    input  logic [fba_pkg::OPCODE_W-1:0] in_opcode,
    input  logic [fba_pkg::IDX_W-1:0]    in_block_index,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [fba_pkg::STATUS_W-1:0] out_status,
    output logic [fba_pkg::IDX_W-1:0]    out_granted_block,
    output logic [fba_pkg::CNT_W-1:0]    out_free_count
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_BLOCK = IW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_BLOCKS);
    localparam logic [SW-1:0] FULL_STACK = SW'(STACK_DEPTH);

    logic                          map_mem [NUM_BLOCKS];
    logic                          map_rdata_reg;
    logic [IW-1:0]                 stack_mem [STACK_DEPTH];
    logic [IW-1:0]                 stack_rdata_reg;

    logic [fba_pkg::OPCODE_W-1:0]  req_op_reg;
    logic [fba_pkg::IDX_W-1:0]     req_idx_reg;
    logic [SW-1:0]                 stack_count_reg, stack_count_next;
    logic [CW-1:0]                 clear_count_reg, clear_count_next;
    logic [IW-1:0]                 scan_start_reg, scan_start_next;
    logic [IW-1:0]                 scan_addr_reg, scan_addr_next;
    logic                          scan_done_reg, scan_done_next;
    logic [IW-1:0]                 first_reg, first_next;
    logic [IW-1:0]                 clr_addr_reg, clr_addr_next;
    logic                          clr_done_reg, clr_done_next;
    logic                          out_valid_reg, out_valid_next;
    logic [fba_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [fba_pkg::IDX_W-1:0]     grant_reg, grant_next;
    logic [fba_pkg::CNT_W-1:0]     count_out_reg, count_out_next;

    logic [31:0]                   req_wide;
    logic [IW-1:0]                 req_blk;
    logic [31:0]                   grant_wide;
    logic [31:0]                   count_wide;
    logic [SW-1:0]                 count_dec;
    logic [AW-1:0]                 stk_waddr;
    logic [AW-1:0]                 stk_raddr;
    logic                          stk_we;
    logic                          stk_re;
    logic [IW-1:0]                 stk_wdata;
    logic                          map_we;
    logic                          map_re;
    logic                          map_wdata;
    logic [IW-1:0]                 map_waddr;
    logic [IW-1:0]                 map_raddr;
    logic                          out_free;

    assign req_wide   = 32'(req_idx_reg);
    assign req_blk    = req_wide[IW-1:0];
    assign grant_wide = 32'(stack_rdata_reg);
    assign count_wide = 32'(clear_count_reg);
    assign count_dec  = stack_count_reg - SW'(1);
    assign stk_waddr  = stack_count_reg[AW-1:0];
    assign stk_raddr  = count_dec[AW-1:0];
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.req_free    = (req_op_reg == fba_pkg::OP_FREE);
    assign stat.req_bad     = (req_wide >= 32'(NUM_BLOCKS));
    assign stat.stack_empty = (stack_count_reg == '0);
    assign stat.stack_full  = (stack_count_reg == FULL_STACK);
    assign stat.clear_zero  = (clear_count_reg == '0);
    assign stat.scan_done   = scan_done_reg;
    assign stat.clr_done    = clr_done_reg;
    assign stat.out_free    = out_free;

    assign stk_we    = (cmd.scan_chk && !map_rdata_reg) || cmd.push;
    assign stk_wdata = cmd.push ? req_blk : scan_addr_reg;
    assign stk_re    = cmd.pop_rd || cmd.fl_rd_stk;

    assign map_re    = cmd.map_rd_scan || cmd.fl_rd_map;
    assign map_raddr = cmd.map_rd_scan ? scan_addr_reg : stack_rdata_reg;

    always_comb
    begin
        map_we    = 1'b0;
        map_wdata = 1'b0;
        map_waddr = stack_rdata_reg;
        if (cmd.init_clr)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr_reg;
        end
        else if (cmd.scan_chk)
        begin
            map_we    = !map_rdata_reg;
            map_wdata = 1'b1;
            map_waddr = scan_addr_reg;
        end
        else if (cmd.fl_wr)
        begin
            map_we = map_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stack_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg  <= in_opcode;
            req_idx_reg <= in_block_index;
        end
    end

    always_comb
    begin
        stack_count_next = stack_count_reg;
        clear_count_next = clear_count_reg;
        scan_start_next  = scan_start_reg;
        scan_addr_next   = scan_addr_reg;
        scan_done_next   = scan_done_reg;
        first_next       = first_reg;
        clr_addr_next    = clr_addr_reg;
        clr_done_next    = clr_done_reg;

        if (cmd.init_clr)
        begin
            clr_addr_next = clr_addr_reg + IW'(1);
            if (clr_addr_reg == LAST_BLOCK)
            begin
                clr_done_next = 1'b1;
            end
        end
        if (cmd.scan_init)
        begin
            scan_addr_next = scan_start_reg;
            scan_done_next = 1'b0;
        end
        if (cmd.scan_chk)
        begin
            scan_addr_next = scan_addr_reg + IW'(1);
            if (scan_addr_reg == LAST_BLOCK)
            begin
                scan_done_next = 1'b1;
            end
            if (!map_rdata_reg)
            begin
                stack_count_next = stack_count_reg + SW'(1);
                if (stack_count_reg == '0)
                begin
                    first_next = scan_addr_reg;
                end
                if (clear_count_reg != '0)
                begin
                    clear_count_next = clear_count_reg - CW'(1);
                end
            end
        end
        if (cmd.pop_rd || cmd.fl_rd_stk)
        begin
            stack_count_next = count_dec;
        end
        if (cmd.fl_wr && map_rdata_reg && (clear_count_reg != FULL_COUNT))
        begin
            clear_count_next = clear_count_reg + CW'(1);
        end
        if (cmd.push)
        begin
            stack_count_next = stack_count_reg + SW'(1);
            scan_start_next  = req_blk;
        end
        if (cmd.set_start_first)
        begin
            scan_start_next = first_reg;
        end
        if (cmd.zero_start)
        begin
            scan_start_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        grant_next     = grant_reg;
        count_out_next = count_out_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            count_out_next = count_wide[fba_pkg::CNT_W-1:0];
            grant_next     = '0;
            case (cmd.out_sel)
                fba_pkg::SEL_GRANT:
                begin
                    status_next = fba_pkg::STATUS_OK;
                    grant_next  = grant_wide[fba_pkg::IDX_W-1:0];
                end
                fba_pkg::SEL_FREED: status_next = fba_pkg::STATUS_OK;
                fba_pkg::SEL_NONE:  status_next = fba_pkg::STATUS_NONE;
                fba_pkg::SEL_RANGE: status_next = fba_pkg::STATUS_RANGE;
                default:            status_next = fba_pkg::STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            clear_count_reg <= FULL_COUNT;
            scan_start_reg  <= '0;
            scan_done_reg   <= 1'b0;
            clr_addr_reg    <= '0;
            clr_done_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            clear_count_reg <= clear_count_next;
            scan_start_reg  <= scan_start_next;
            scan_done_reg   <= scan_done_next;
            clr_addr_reg    <= clr_addr_next;
            clr_done_reg    <= clr_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        first_reg     <= first_next;
        status_reg    <= status_next;
        grant_reg     <= grant_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = status_reg;
    assign out_granted_block = grant_reg;
    assign out_free_count    = count_out_reg;

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= FULL_STACK)
        else $error("stack count above depth");
    a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clear_count_reg <= FULL_COUNT)
        else $error("clear count above block count");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.scan_chk) |-> !stat.stack_full)
        else $error("push onto full stack");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overwritten");
    a_map_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (map_we && !cmd.init_clr) |-> clr_done_reg)
        else $error("bitmap written during clearing pass");
`endif

endmodule

[sv/fba_controller.sv]
module fba_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fba_pkg::stat_t stat,
    output fba_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_POP_OUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FL_CHECK,
        S_FL_RD_MAP,
        S_FL_WR,
        S_PUSH,
        S_RPT_NONE,
        S_RPT_RANGE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = fba_pkg::SEL_GRANT;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_clr = !stat.clr_done;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req_free)
                begin
                    if (stat.req_bad)
                    begin
                        state_next = S_RPT_RANGE;
                    end
                    else if (stat.stack_full)
                    begin
                        state_next = S_FL_CHECK;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (!stat.stack_empty)
                begin
                    state_next = S_POP_RD;
                end
                else if (stat.clear_zero)
                begin
                    state_next = S_RPT_NONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = fba_pkg::SEL_GRANT;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.stack_full || stat.scan_done)
                begin
                    if (stat.stack_empty)
                    begin
                        state_next = S_RPT_NONE;
                    end
                    else
                    begin
                        cmd.set_start_first = 1'b1;
                        state_next          = S_POP_RD;
                    end
                end
                else
                begin
                    cmd.map_rd_scan = 1'b1;
                    state_next      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_FL_CHECK:
            begin
                if (stat.stack_empty)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.fl_rd_stk = 1'b1;
                    state_next    = S_FL_RD_MAP;
                end
            end
            S_FL_RD_MAP:
            begin
                cmd.fl_rd_map = 1'b1;
                state_next    = S_FL_WR;
            end
            S_FL_WR:
            begin
                cmd.fl_wr  = 1'b1;
                state_next = S_FL_CHECK;
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = fba_pkg::SEL_FREED;
                    state_next   = S_IDLE;
                end
            end
            S_RPT_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.zero_start = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = fba_pkg::SEL_NONE;
                    state_next     = S_IDLE;
                end
            end
            S_RPT_RANGE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = fba_pkg::SEL_RANGE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_DECODE))
        else $error("accepted transfer not decoded");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_rd || cmd.fl_rd_stk) |-> !stat.stack_empty)
        else $error("pop from empty stack");
    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.clr_done |-> !in_ready)
        else $error("request taken during clearing pass");
`endif

endmodule

[sv/free_block_stack_allocator.sv]
// Channel | Dir | Fields                                         | Transfer
// req     | in  | opcode[0:0], block_index[9:0]                  | valid && ready
// rsp     | out | status[1:0], granted_block[9:0], free_count[10:0] | valid && ready
//
// A pop passes decode, stack read and result load, and a push decode and push; then the FSM is idle.
// A refill scan examines each block with a bitmap read and a check (one bitmap read port).
// A flush handles each stack entry with a stack read, a bitmap read and a bitmap write.
// After reset a clearing pass writes the bitmap; req.ready stays low until the pass is done.
// The result register lets the next request enter while a result waits on rsp.ready.
module free_block_stack_allocator #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fba_req_if.sink   req,
    fba_rsp_if.source rsp
);

    fba_pkg::cmd_t  cmd;
    fba_pkg::stat_t stat;

    fba_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fba_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_opcode         (req.opcode),
        .in_block_index    (req.block_index),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_status        (rsp.status),
        .out_granted_block (rsp.granted_block),
        .out_free_count    (rsp.free_count)
    );

endmodule

[dv/free_block_stack_allocator_tb.sv]
module free_block_stack_allocator_tb;

    localparam int NUM_BLOCKS     = 1024;
    localparam int STACK_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int FILL_CAP       = 1500;
    localparam int MIXED_ITEMS    = 300;
    localparam int QUIET_TAIL     = 100;

    typedef struct packed {
        logic [fba_pkg::STATUS_W-1:0] status;
        logic [fba_pkg::IDX_W-1:0]    granted_block;
        logic [fba_pkg::CNT_W-1:0]    free_count;
    } alloc_result_t;

    class alloc_scoreboard;
        bit                        used_map [NUM_BLOCKS];
        logic [fba_pkg::IDX_W-1:0] ready_stack [STACK_DEPTH];
        int unsigned               stack_count;
        int unsigned               clear_count;
        int unsigned               scan_start;
        alloc_result_t             expected_q [$];
        int                        errors;
        int                        checked;
        int                        allocs;
        int                        frees;
        int                        exhausted_hits;
        int                        empty_scans;
        int                        flushes;

        function new();
            foreach (used_map[i])
                used_map[i] = 1'b0;
            stack_count    = 0;
            clear_count    = NUM_BLOCKS;
            scan_start     = 0;
            errors         = 0;
            checked        = 0;
            allocs         = 0;
            frees          = 0;
            exhausted_hits = 0;
            empty_scans    = 0;
            flushes        = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned refill();
            int unsigned pushed;
            pushed = 0;
            for (int unsigned i = scan_start; i < NUM_BLOCKS && stack_count < STACK_DEPTH; i++)
            begin
                if (!used_map[i])
                begin
                    ready_stack[stack_count] = fba_pkg::IDX_W'(i);
                    stack_count++;
                    used_map[i] = 1'b1;
                    pushed++;
                end
            end
            clear_count = (pushed > clear_count) ? 0 : clear_count - pushed;
            return pushed;
        endfunction

        function void flush();
            logic [fba_pkg::IDX_W-1:0] blk;
            flushes++;
            while (stack_count > 0)
            begin
                stack_count--;
                blk = ready_stack[stack_count];
                if (used_map[blk])
                begin
                    used_map[blk] = 1'b0;
                    if (clear_count < NUM_BLOCKS)
                        clear_count++;
                end
            end
        endfunction

        function alloc_result_t note_request(logic [fba_pkg::OPCODE_W-1:0] op,
                                             logic [fba_pkg::IDX_W-1:0] idx);
            alloc_result_t r;
            r.status        = fba_pkg::STATUS_OK;
            r.granted_block = '0;
            if (op == fba_pkg::OP_ALLOC)
            begin
                allocs++;
                if (stack_count == 0)
                begin
                    if (clear_count == 0)
                    begin
                        scan_start = 0;
                        r.status   = fba_pkg::STATUS_NONE;
                        exhausted_hits++;
                    end
                    else if (refill() == 0)
                    begin
                        scan_start = 0;
                        r.status   = fba_pkg::STATUS_NONE;
                        empty_scans++;
                    end
                    else
                        scan_start = ready_stack[0];
                end
                if (r.status == fba_pkg::STATUS_OK)
                begin
                    stack_count--;
                    r.granted_block = ready_stack[stack_count];
                end
            end
            else
            begin
                frees++;
                if (int'(idx) >= NUM_BLOCKS)
                    r.status = fba_pkg::STATUS_RANGE;
                else
                begin
                    if (stack_count >= STACK_DEPTH)
                        flush();
                    ready_stack[stack_count] = idx;
                    stack_count++;
                    scan_start = idx;
                end
            end
            r.free_count = fba_pkg::CNT_W'(clear_count);
            expected_q.push_back(r);
            return r;
        endfunction

        function void check_response(logic [fba_pkg::STATUS_W-1:0] status,
                                     logic [fba_pkg::IDX_W-1:0] granted,
                                     logic [fba_pkg::CNT_W-1:0] count);
            alloc_result_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: status %0d block %0d count %0d",
                         $time, status, granted, count);
            end
            else
            begin
                e = expected_q.pop_front();
                if (status !== e.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, e.status, status);
                end
                if (granted !== e.granted_block)
                begin
                    errors++;
                    $display("%0t: granted_block mismatch: expected %0d, actual %0d",
                             $time, e.granted_block, granted);
                end
                if (count !== e.free_count)
                begin
                    errors++;
                    $display("%0t: free_count mismatch: expected %0d, actual %0d",
                             $time, e.free_count, count);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   gaps_on;
    int   requests_sent;

    logic [fba_pkg::IDX_W-1:0] held_blocks [$];
    alloc_scoreboard           sb;

    fba_req_if req_ch ();
    fba_rsp_if rsp_ch ();

    free_block_stack_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response(rsp_ch.status, rsp_ch.granted_block, rsp_ch.free_count);
    end

    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall--;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready = 1'b0;
                stall = $urandom_range(0, 2);
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(input logic [fba_pkg::OPCODE_W-1:0] op,
                                input logic [fba_pkg::IDX_W-1:0] idx);
        alloc_result_t r;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.opcode      = op;
        req_ch.block_index = idx;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        r = sb.note_request(op, idx);
        if (op == fba_pkg::OP_ALLOC && r.status == fba_pkg::STATUS_OK)
            held_blocks.push_back(r.granted_block);
        requests_sent++;
    endtask

    task automatic send_alloc();
        send_request(fba_pkg::OP_ALLOC, fba_pkg::IDX_W'($urandom));
    endtask

    // keep: leave the block in the held list so it gets freed twice
    task automatic free_held(input bit keep);
        int                        pos;
        logic [fba_pkg::IDX_W-1:0] blk;
        if (held_blocks.size() == 0)
            send_request(fba_pkg::OP_FREE, fba_pkg::IDX_W'($urandom_range(0, NUM_BLOCKS - 1)));
        else
        begin
            pos = $urandom_range(0, held_blocks.size() - 1);
            blk = held_blocks[pos];
            if (!keep)
                held_blocks.delete(pos);
            send_request(fba_pkg::OP_FREE, blk);
        end
    endtask

    initial
    begin
        int mixed_sent;
        int run_len;
        int fill_sent;
        bit drained;

        sb = new();
        gaps_on            = 1'b1;
        requests_sent      = 0;
        drained            = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = fba_pkg::OP_ALLOC;
        req_ch.block_index = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(fba_pkg::OP_ALLOC, '0);
        send_request(fba_pkg::OP_ALLOC, '1);
        send_request(fba_pkg::OP_FREE, 10'd1023);
        send_alloc();
        send_alloc();
        send_request(fba_pkg::OP_FREE, 10'd1023);
        send_alloc();
        send_alloc();
        send_alloc();
        send_request(fba_pkg::OP_FREE, 10'd0);
        send_request(fba_pkg::OP_FREE, 10'h155);
        send_request(fba_pkg::OP_FREE, 10'h2AA);
        send_request(fba_pkg::OP_FREE, 10'd512);
        send_request(fba_pkg::OP_ALLOC, 10'h155);
        send_request(fba_pkg::OP_ALLOC, 10'h2AA);
        send_alloc();
        send_alloc();

        // fill the map until nothing is clear, or until FILL_CAP requests are sent
        fill_sent = 0;
        while (!(sb.clear_count == 0 && sb.stack_count == 0) && fill_sent < FILL_CAP)
        begin
            if (fill_sent % 50 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 97)
                send_alloc();
            else
                free_held(1'b0);
            fill_sent++;
        end
        repeat (3) send_alloc();

        mixed_sent = 0;
        gaps_on    = 1'b1;
        while (mixed_sent < MIXED_ITEMS)
        begin
            if (!drained && mixed_sent >= MIXED_ITEMS / 2)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            if (mixed_sent >= MIXED_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    run_len = $urandom_range(1, 40);
                    repeat (run_len) free_held(1'b0);
                end
                4, 5, 6, 7:
                begin
                    run_len = $urandom_range(1, 40);
                    repeat (run_len) send_alloc();
                end
                8:
                begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_request(fba_pkg::OP_FREE, fba_pkg::IDX_W'($urandom));
                        else
                            send_alloc();
                    end
                end
                default:
                begin
                    run_len = 2;
                    free_held(1'b1);
                    free_held(1'b0);
                end
            endcase
            mixed_sent += run_len;
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d results for %0d requests (%0d alloc, %0d free)",
                 sb.checked, requests_sent, sb.allocs, sb.frees);
        $display("Map exhausted %0d times, empty scans %0d, stack flushes %0d",
                 sb.exhausted_hits, sb.empty_scans, sb.flushes);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
